[sv/hlps_pkg.sv]
`default_nettype none

package hlps_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PING_INTERVAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUICK_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_THRESHOLD = 2'd2;

    localparam logic [31:0] PING_INTERVAL_RST  = 32'd360000;
    localparam logic [31:0] QUICK_INTERVAL_RST = 32'd5000;
    localparam logic [31:0] DEAD_THRESHOLD_RST = 32'd30000;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_REPLY = 2'd1;
    localparam logic [1:0] CMD_ARM   = 2'd2;

    localparam logic [1:0] EV_CHECKED      = 2'd0;
    localparam logic [1:0] EV_REPLY_OK     = 2'd1;
    localparam logic [1:0] EV_REPLY_IGNORE = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [39:0] now_ms;
        logic [5:0]  host;
        logic [15:0] reply_seq;
        logic        link_ok;
        logic [15:0] jitter_ms;
        logic        enable;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  host_index;
        logic [1:0]  event_kind;
        logic        ping_request;
        logic [15:0] ping_number;
        logic        host_live;
        logic        went_dead;
        logic        went_live;
        logic [39:0] next_due_ms;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ARM,
        ST_REPLY_RD,
        ST_REPLY,
        ST_SCAN,
        ST_PICK,
        ST_SINCE,
        ST_ELAPSE,
        ST_STARTUP,
        ST_LIM_PQ,
        ST_CMP_PQ,
        ST_LIM_PD,
        ST_CMP_PD,
        ST_LIM_MD,
        ST_CMP_MD,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ND_NOW_QI,
        ND_NOW_PI,
        ND_LC_PI
    } nd_sel_t;

endpackage

`default_nettype wire

[sv/hlps_alu.sv]
`default_nettype none

module hlps_alu #(
    parameter int W = 42
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic         sub,
    output logic [W-1:0]      sum
);

    logic [W-1:0] b_op;

    assign b_op = sub ? ~b : b;
    assign sum  = a + b_op + W'(sub);

endmodule

`default_nettype wire

[sv/host_liveness_ping_scheduler.sv]
// Host liveness ping scheduler.
// Input channel (in_valid/in_stall/in_data) takes one item at a time: tick, reply or arm.
// Output channel (out_valid/out_stall/out_data) carries at most one result per item.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the three interval
// registers; cfg_ready is always high, writes belong in idle periods only.
// in_stall is high whenever an item is in work.
// Item handling, all arithmetic through one shared add/subtract unit:
//   arm   : one state writes the host's tables and returns to idle
//   reply : a table read, the live update, then the output hand-off
//   tick  : a due-soonest scan (one table entry per cycle,
//           one table read port), then the check and reschedule states.
// A tick with no due host gives no result and ends after the scan.
// A finished result waits in ST_DONE while the output register is full and stalled;
// the held beat does not change until taken.
// Reset clears the live and active flags, the ping counter and the output valid,
// sets the startup phase, and loads the register defaults. The host time tables
// need no clearing pass: a host's entries are written when it is armed.
`default_nettype none

module host_liveness_ping_scheduler #(
    parameter int HOSTS     = 64,
    parameter int TIME_BITS = 40
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire hlps_pkg::in_item_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output hlps_pkg::out_item_t                      out_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [hlps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [31:0]                         cfg_data
);

    localparam int TB = TIME_BITS;
    localparam int W  = TIME_BITS + 2;
    localparam int HW = (HOSTS > 1) ? $clog2(HOSTS) : 1;
    localparam int CW = $clog2(HOSTS + 1);

    hlps_pkg::state_t    state_reg, state_next;
    logic [HOSTS-1:0]    live_reg, live_next;
    logic [HOSTS-1:0]    active_reg, active_next;
    logic                in_startup_reg, in_startup_next;
    logic [TB-1:0]       sb_reg, sb_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                found_reg, found_next;
    logic [15:0]         ping_cnt_reg, ping_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         pi_reg, qi_reg, dt_reg;

    hlps_pkg::in_item_t  item_reg, item_next;
    logic [HW-1:0]       best_idx_reg, best_idx_next;
    logic [TB-1:0]       best_time_reg, best_time_next;
    logic [HW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [TB-1:0]       since_reg, since_next;
    logic [TB-1:0]       el_reg, el_next;
    logic [W-1:0]        lim_reg, lim_next;
    logic                hs_reg, hs_next;
    logic                ping_reg, ping_next;
    logic                dead_reg, dead_next;
    logic [15:0]         num_reg, num_next;
    logic [TB-1:0]       lc_eff_reg, lc_eff_next;
    hlps_pkg::nd_sel_t   nd_sel_reg, nd_sel_next;
    hlps_pkg::out_item_t res_reg, res_next;
    hlps_pkg::out_item_t out_data_reg, out_data_next;

    logic [TB-1:0] lr_mem  [HOSTS];
    logic [TB-1:0] lc_mem  [HOSTS];
    logic [TB-1:0] nct_mem [HOSTS];
    logic [15:0]   exp_mem [HOSTS];
    logic [TB-1:0] lr_q, lc_q, nct_q;
    logic [15:0]   exp_q;
    logic [HW-1:0] rd_addr;

    logic          lr_we, lc_we, nct_we, exp_we;
    logic [HW-1:0] lr_wa, lc_wa, nct_wa, exp_wa;

    logic [W-1:0]  alu_a, alu_b, alu_sum;
    logic          alu_sub, alu_neg;

    logic          in_acc, in_host_ok;
    logic [TB-1:0] now_t;
    logic [HW-1:0] item_idx;
    logic          ping_now, reply_ok;

    hlps_alu #(
        .W(W)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    assign alu_neg    = alu_sum[W-1];
    assign in_stall   = (state_reg != hlps_pkg::ST_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign in_host_ok = (32'(in_data.host) < 32'(HOSTS));
    assign now_t      = TB'(item_reg.now_ms);
    assign item_idx   = HW'(item_reg.host);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        case (state_reg)
            hlps_pkg::ST_SCAN:
                rd_addr = cnt_reg[HW-1:0];
            hlps_pkg::ST_IDLE, hlps_pkg::ST_REPLY_RD, hlps_pkg::ST_REPLY:
                rd_addr = item_idx;
            default:
                rd_addr = best_idx_reg;
        endcase
    end

    // shared unit operand select
    always_comb
    begin
        alu_a   = W'(now_t);
        alu_b   = W'(best_time_reg);
        alu_sub = 1'b1;
        case (state_reg)
            hlps_pkg::ST_ARM:
            begin
                alu_b   = W'(item_reg.jitter_ms);
                alu_sub = 1'b0;
            end
            hlps_pkg::ST_SCAN:
            begin
                alu_a = W'(nct_q);
                alu_b = W'(best_time_reg);
            end
            hlps_pkg::ST_PICK:
                alu_b = W'(best_time_reg);
            hlps_pkg::ST_SINCE:
                alu_b = W'(lr_q);
            hlps_pkg::ST_ELAPSE:
                alu_b = W'(sb_reg);
            hlps_pkg::ST_STARTUP:
            begin
                alu_a = W'(pi_reg);
                alu_b = W'(el_reg);
            end
            hlps_pkg::ST_LIM_PQ:
            begin
                alu_a = W'(pi_reg);
                alu_b = W'(qi_reg);
            end
            hlps_pkg::ST_LIM_PD:
            begin
                alu_a   = W'(pi_reg);
                alu_b   = W'(dt_reg);
                alu_sub = 1'b0;
            end
            hlps_pkg::ST_LIM_MD:
            begin
                alu_a = W'(pi_reg);
                alu_b = W'(dt_reg);
            end
            hlps_pkg::ST_CMP_PQ, hlps_pkg::ST_CMP_PD, hlps_pkg::ST_CMP_MD:
            begin
                alu_a = W'(since_reg);
                alu_b = lim_reg;
            end
            hlps_pkg::ST_NEXT:
            begin
                alu_sub = 1'b0;
                case (nd_sel_reg)
                    hlps_pkg::ND_NOW_QI:
                    begin
                        alu_a = W'(now_t);
                        alu_b = W'(qi_reg);
                    end
                    hlps_pkg::ND_NOW_PI:
                    begin
                        alu_a = W'(now_t);
                        alu_b = W'(pi_reg);
                    end
                    default:
                    begin
                        alu_a = W'(lc_eff_reg);
                        alu_b = W'(pi_reg);
                    end
                endcase
            end
            default:
            begin
                alu_a = W'(now_t);
                alu_b = W'(best_time_reg);
            end
        endcase
    end

    assign ping_now = hs_reg || !alu_neg;
    assign reply_ok = active_reg[item_idx] && (item_reg.reply_seq == exp_q);

    // table write ports
    always_comb
    begin
        lr_we  = 1'b0;
        lc_we  = 1'b0;
        nct_we = 1'b0;
        exp_we = 1'b0;
        lr_wa  = item_idx;
        lc_wa  = item_idx;
        nct_wa = item_idx;
        exp_wa = best_idx_reg;
        case (state_reg)
            hlps_pkg::ST_ARM:
            begin
                lr_we  = item_reg.enable;
                lc_we  = item_reg.enable;
                nct_we = item_reg.enable;
            end
            hlps_pkg::ST_REPLY:
                lr_we = reply_ok;
            hlps_pkg::ST_CMP_PQ:
            begin
                lc_we  = ping_now && item_reg.link_ok;
                lc_wa  = best_idx_reg;
                exp_we = ping_now && item_reg.link_ok;
            end
            hlps_pkg::ST_NEXT:
            begin
                nct_we = 1'b1;
                nct_wa = best_idx_reg;
            end
            default:
            begin
                lr_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (lr_we)
        begin
            lr_mem[lr_wa] <= now_t;
        end
        if (lc_we)
        begin
            lc_mem[lc_wa] <= now_t;
        end
        if (nct_we)
        begin
            nct_mem[nct_wa] <= alu_sum[TB-1:0];
        end
        if (exp_we)
        begin
            exp_mem[exp_wa] <= ping_cnt_reg;
        end
        lr_q  <= lr_mem[rd_addr];
        lc_q  <= lc_mem[rd_addr];
        nct_q <= nct_mem[rd_addr];
        exp_q <= exp_mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        live_next       = live_reg;
        active_next     = active_reg;
        in_startup_next = in_startup_reg;
        sb_next         = sb_reg;
        cnt_next        = cnt_reg;
        cmp_vld_next    = 1'b0;
        found_next      = found_reg;
        ping_cnt_next   = ping_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        item_next       = item_reg;
        best_idx_next   = best_idx_reg;
        best_time_next  = best_time_reg;
        cmp_idx_next    = cmp_idx_reg;
        since_next      = since_reg;
        el_next         = el_reg;
        lim_next        = lim_reg;
        hs_next         = hs_reg;
        ping_next       = ping_reg;
        dead_next       = dead_reg;
        num_next        = num_reg;
        lc_eff_next     = lc_eff_reg;
        nd_sel_next     = nd_sel_reg;
        res_next        = res_reg;
        out_data_next   = out_data_reg;

        case (state_reg)
            hlps_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    item_next = in_data;
                    case (in_data.cmd)
                        hlps_pkg::CMD_TICK:
                        begin
                            cnt_next   = '0;
                            found_next = 1'b0;
                            state_next = hlps_pkg::ST_SCAN;
                        end
                        hlps_pkg::CMD_REPLY:
                            state_next = in_host_ok ? hlps_pkg::ST_REPLY_RD
                                                    : hlps_pkg::ST_IDLE;
                        hlps_pkg::CMD_ARM:
                            state_next = in_host_ok ? hlps_pkg::ST_ARM
                                                    : hlps_pkg::ST_IDLE;
                        default:
                            state_next = hlps_pkg::ST_IDLE;
                    endcase
                end
            end

            hlps_pkg::ST_ARM:
            begin
                active_next[item_idx] = item_reg.enable;
                if (item_reg.enable)
                begin
                    live_next[item_idx] = 1'b0;
                    sb_next             = now_t;
                    in_startup_next     = 1'b1;
                end
                state_next = hlps_pkg::ST_IDLE;
            end

            hlps_pkg::ST_REPLY_RD:
                state_next = hlps_pkg::ST_REPLY;

            hlps_pkg::ST_REPLY:
            begin
                if (reply_ok)
                begin
                    live_next[item_idx] = 1'b1;
                end
                res_next.host_index   = item_reg.host;
                res_next.event_kind   = reply_ok ? hlps_pkg::EV_REPLY_OK
                                                 : hlps_pkg::EV_REPLY_IGNORE;
                res_next.ping_request = 1'b0;
                res_next.ping_number  = '0;
                res_next.host_live    = live_reg[item_idx] || reply_ok;
                res_next.went_dead    = 1'b0;
                res_next.went_live    = reply_ok && !live_reg[item_idx];
                res_next.next_due_ms  = 40'(nct_q);
                state_next            = hlps_pkg::ST_DONE;
            end

            hlps_pkg::ST_SCAN:
            begin
                // read entry cnt, compare the entry read in the previous cycle
                if (cmp_vld_reg && active_reg[cmp_idx_reg] && (!found_reg || alu_neg))
                begin
                    found_next     = 1'b1;
                    best_idx_next  = cmp_idx_reg;
                    best_time_next = nct_q;
                end
                if (cnt_reg == CW'(HOSTS))
                begin
                    state_next = hlps_pkg::ST_PICK;
                end
                else
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = cnt_reg[HW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
            end

            hlps_pkg::ST_PICK:
                state_next = (found_reg && !alu_neg) ? hlps_pkg::ST_SINCE
                                                     : hlps_pkg::ST_IDLE;

            hlps_pkg::ST_SINCE:
            begin
                since_next = alu_neg ? '0 : alu_sum[TB-1:0];
                state_next = hlps_pkg::ST_ELAPSE;
            end

            hlps_pkg::ST_ELAPSE:
            begin
                el_next    = alu_neg ? '0 : alu_sum[TB-1:0];
                state_next = hlps_pkg::ST_STARTUP;
            end

            hlps_pkg::ST_STARTUP:
            begin
                // startup ends once elapsed exceeds the interval
                in_startup_next = in_startup_reg && !alu_neg;
                hs_next         = in_startup_reg && !alu_neg && !live_reg[best_idx_reg];
                state_next      = hlps_pkg::ST_LIM_PQ;
            end

            hlps_pkg::ST_LIM_PQ:
            begin
                lim_next   = alu_sum;
                state_next = hlps_pkg::ST_CMP_PQ;
            end

            hlps_pkg::ST_CMP_PQ:
            begin
                ping_next = ping_now;
                dead_next = 1'b0;
                num_next  = ping_now ? ping_cnt_reg : 16'd0;
                if (ping_now)
                begin
                    ping_cnt_next = ping_cnt_reg + 16'd1;
                end
                lc_eff_next = (ping_now && item_reg.link_ok) ? now_t : lc_q;
                if (hs_reg)
                begin
                    nd_sel_next = hlps_pkg::ND_NOW_QI;
                    state_next  = hlps_pkg::ST_NEXT;
                end
                else if (live_reg[best_idx_reg])
                begin
                    state_next = hlps_pkg::ST_LIM_PD;
                end
                else
                begin
                    nd_sel_next = hlps_pkg::ND_LC_PI;
                    state_next  = hlps_pkg::ST_NEXT;
                end
            end

            hlps_pkg::ST_LIM_PD:
            begin
                lim_next   = alu_sum;
                state_next = hlps_pkg::ST_CMP_PD;
            end

            hlps_pkg::ST_CMP_PD:
            begin
                if (!alu_neg)
                begin
                    live_next[best_idx_reg] = 1'b0;
                    dead_next               = 1'b1;
                    nd_sel_next             = hlps_pkg::ND_NOW_PI;
                    state_next              = hlps_pkg::ST_NEXT;
                end
                else
                begin
                    state_next = hlps_pkg::ST_LIM_MD;
                end
            end

            hlps_pkg::ST_LIM_MD:
            begin
                lim_next   = alu_sum;
                state_next = hlps_pkg::ST_CMP_MD;
            end

            hlps_pkg::ST_CMP_MD:
            begin
                nd_sel_next = alu_neg ? hlps_pkg::ND_LC_PI : hlps_pkg::ND_NOW_QI;
                state_next  = hlps_pkg::ST_NEXT;
            end

            hlps_pkg::ST_NEXT:
            begin
                res_next.host_index   = 6'(best_idx_reg);
                res_next.event_kind   = hlps_pkg::EV_CHECKED;
                res_next.ping_request = ping_reg;
                res_next.ping_number  = num_reg;
                res_next.host_live    = live_reg[best_idx_reg];
                res_next.went_dead    = dead_reg;
                res_next.went_live    = 1'b0;
                res_next.next_due_ms  = 40'(alu_sum[TB-1:0]);
                state_next            = hlps_pkg::ST_DONE;
            end

            hlps_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = hlps_pkg::ST_IDLE;
                end
            end

            default:
                state_next = hlps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hlps_pkg::ST_IDLE;
            live_reg       <= '0;
            active_reg     <= '0;
            in_startup_reg <= 1'b1;
            sb_reg         <= '0;
            cnt_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            ping_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            pi_reg         <= hlps_pkg::PING_INTERVAL_RST;
            qi_reg         <= hlps_pkg::QUICK_INTERVAL_RST;
            dt_reg         <= hlps_pkg::DEAD_THRESHOLD_RST;
        end
        else
        begin
            state_reg      <= state_next;
            live_reg       <= live_next;
            active_reg     <= active_next;
            in_startup_reg <= in_startup_next;
            sb_reg         <= sb_next;
            cnt_reg        <= cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            found_reg      <= found_next;
            ping_cnt_reg   <= ping_cnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hlps_pkg::CFG_PING_INTERVAL:  pi_reg <= cfg_data;
                    hlps_pkg::CFG_QUICK_INTERVAL: qi_reg <= cfg_data;
                    hlps_pkg::CFG_DEAD_THRESHOLD: dt_reg <= cfg_data;
                    default:
                    begin
                        pi_reg <= pi_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        best_idx_reg  <= best_idx_next;
        best_time_reg <= best_time_next;
        cmp_idx_reg   <= cmp_idx_next;
        since_reg     <= since_next;
        el_reg        <= el_next;
        lim_reg       <= lim_next;
        hs_reg        <= hs_next;
        ping_reg      <= ping_next;
        dead_reg      <= dead_next;
        num_reg       <= num_next;
        lc_eff_reg    <= lc_eff_next;
        nd_sel_reg    <= nd_sel_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

endmodule

`default_nettype wire

[tb/host_liveness_ping_scheduler_test.sv]
`default_nettype none

module host_liveness_ping_scheduler_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hlps_pkg::*;

    localparam int HOSTS       = 64;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 140;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_LIMIT = 20000;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // host table as the scheduler should hold it
    bit          alive_tbl[HOSTS];
    bit          armed_tbl[HOSTS];
    bit          ever_armed[HOSTS];
    bit          seq_known[HOSTS];
    bit [39:0]   resp_ms[HOSTS];
    bit [39:0]   check_ms[HOSTS];
    bit [39:0]   due_ms[HOSTS];
    bit [15:0]   want_seq[HOSTS];
    bit [15:0]   seq_ctr = '0;
    bit          warmup = 1'b1;
    bit [39:0]   warmup_ms = '0;
    bit [31:0]   ping_iv  = PING_INTERVAL_RST;
    bit [31:0]   quick_iv = QUICK_INTERVAL_RST;
    bit [31:0]   dead_gr  = DEAD_THRESHOLD_RST;

    out_item_t   owed_events[$];
    out_item_t   head_event;

    int          fail_count = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          pings_seen = 0;
    int          deaths_seen = 0;
    int          lives_seen = 0;
    int          cycle_count = 0;
    bit          steady = 1'b0;
    int          stall_left = 0;
    bit          stall_on = 1'b0;

    host_liveness_ping_scheduler #(
        .HOSTS     (HOSTS),
        .TIME_BITS (40)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic bit [39:0] elapsed_ms(bit [39:0] now, bit [39:0] past);
        return (now >= past) ? now - past : 40'd0;
    endfunction

    // negative limit is always met
    function automatic bit meets(bit [39:0] span, longint lim);
        return (lim < 0) || (longint'({24'b0, span}) >= lim);
    endfunction

    function automatic bit schedule_step(input in_item_t it, output out_item_t ev);
        int        best;
        bit [39:0] now;
        bit [39:0] since;
        bit [39:0] nd;
        bit        hs;
        bit        ping;
        bit        dead;
        bit        ok;
        bit        became;
        bit [15:0] num;
        longint    iv;
        longint    qv;
        longint    dv;
        ev = '0;
        now = it.now_ms;
        iv = longint'({32'b0, ping_iv});
        qv = longint'({32'b0, quick_iv});
        dv = longint'({32'b0, dead_gr});
        case (it.cmd)
            CMD_ARM:
            begin
                armed_tbl[it.host] = it.enable;
                if (it.enable)
                begin
                    alive_tbl[it.host] = 1'b0;
                    ever_armed[it.host] = 1'b1;
                    resp_ms[it.host] = now;
                    check_ms[it.host] = now;
                    due_ms[it.host] = now + {24'b0, it.jitter_ms};
                    warmup_ms = now;
                    warmup = 1'b1;
                end
                return 1'b0;
            end
            CMD_REPLY:
            begin
                became = 1'b0;
                ok = armed_tbl[it.host] && (it.reply_seq == want_seq[it.host]);
                if (ok)
                begin
                    resp_ms[it.host] = now;
                    if (!alive_tbl[it.host])
                    begin
                        alive_tbl[it.host] = 1'b1;
                        became = 1'b1;
                    end
                end
                ev.host_index = it.host;
                ev.event_kind = ok ? EV_REPLY_OK : EV_REPLY_IGNORE;
                ev.host_live = alive_tbl[it.host];
                ev.went_live = became;
                ev.next_due_ms = due_ms[it.host];
                return 1'b1;
            end
            CMD_TICK:
            begin
                best = -1;
                dead = 1'b0;
                num = '0;
                for (int k = 0; k < HOSTS; k++)
                    if (armed_tbl[k] && (best < 0 || due_ms[k] < due_ms[best]))
                        best = k;
                if (best < 0 || due_ms[best] > now)
                    return 1'b0;
                since = elapsed_ms(now, resp_ms[best]);
                if (warmup && elapsed_ms(now, warmup_ms) > {8'b0, ping_iv})
                    warmup = 1'b0;
                hs = warmup && !alive_tbl[best];
                ping = hs || meets(since, iv - qv);
                if (ping)
                begin
                    num = seq_ctr;
                    if (it.link_ok)
                    begin
                        check_ms[best] = now;
                        want_seq[best] = num;
                        seq_known[best] = 1'b1;
                    end
                    seq_ctr = seq_ctr + 16'd1;
                end
                if (hs)
                    nd = now + {8'b0, quick_iv};
                else if (alive_tbl[best])
                begin
                    if (meets(since, iv + dv))
                    begin
                        alive_tbl[best] = 1'b0;
                        dead = 1'b1;
                        nd = now + {8'b0, ping_iv};
                    end
                    else if (meets(since, iv - dv))
                        nd = now + {8'b0, quick_iv};
                    else
                        nd = check_ms[best] + {8'b0, ping_iv};
                end
                else
                    nd = check_ms[best] + {8'b0, ping_iv};
                due_ms[best] = nd;
                ev.host_index = 6'(best);
                ev.event_kind = EV_CHECKED;
                ev.ping_request = ping;
                ev.ping_number = num;
                ev.host_live = alive_tbl[best];
                ev.went_dead = dead;
                ev.next_due_ms = nd;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic in_item_t make_item(logic [1:0] cmd, logic [39:0] now, logic [5:0] host,
                                           logic [15:0] seq, logic link, logic [15:0] jit,
                                           logic en);
        in_item_t it;
        it.cmd = cmd;
        it.now_ms = now;
        it.host = host;
        it.reply_seq = seq;
        it.link_ok = link;
        it.jitter_ms = jit;
        it.enable = en;
        return it;
    endfunction

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void field_check(string name, logic [39:0] exp_v, logic [39:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    task automatic send_item(input in_item_t it);
        out_item_t ev;
        int        gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (schedule_step(it, ev))
            owed_events.push_back(ev);
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // only called with the block idle: no beat owed, scan finished
    task automatic load_config(input bit [31:0] iv, input bit [31:0] qv, input bit [31:0] dv);
        logic [CFG_IDX_W-1:0] idx[3];
        bit [31:0]            vals[3];
        idx = '{CFG_PING_INTERVAL, CFG_QUICK_INTERVAL, CFG_DEAD_THRESHOLD};
        vals = '{iv, qv, dv};
        in_valid <= 1'b0;
        while (owed_events.size() != 0)
            @(posedge clk);
        repeat (HOSTS + 20) @(posedge clk);
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                CFG_PING_INTERVAL:  ping_iv = vals[i];
                CFG_QUICK_INTERVAL: quick_iv = vals[i];
                CFG_DEAD_THRESHOLD: dead_gr = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_startup_ping();
        send_item(make_item(CMD_TICK, 40'd0, 6'd0, 16'd0, 1'b1, 16'd0, 1'b0));
        send_item(make_item(CMD_UNUSED, '1, 6'd63, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1));
        send_item(make_item(CMD_ARM, 40'h10, 6'd0, 16'd0, 1'b0, 16'd0, 1'b1));
        send_item(make_item(CMD_ARM, 40'h20, 6'd63, 16'd0, 1'b0, 16'hFFFF, 1'b1));
        send_item(make_item(CMD_TICK, 40'h5, 6'd0, 16'd0, 1'b1, 16'd0, 1'b0));
        send_item(make_item(CMD_TICK, 40'h10, 6'd0, 16'd0, 1'b0, 16'd0, 1'b0));
        send_item(make_item(CMD_TICK, 40'd5016, 6'd0, 16'd0, 1'b1, 16'd0, 1'b0));
    endtask

    task automatic test_replies();
        send_item(make_item(CMD_REPLY, 40'd5020, 6'd0, 16'd1, 1'b0, 16'd0, 1'b0));
        send_item(make_item(CMD_REPLY, 40'd5021, 6'd0, 16'hFFFF, 1'b0, 16'd0, 1'b0));
        send_item(make_item(CMD_REPLY, 40'd5022, 6'd0, 16'd0, 1'b0, 16'd0, 1'b0));
        send_item(make_item(CMD_ARM, 40'd5030, 6'd63, 16'd0, 1'b0, 16'd0, 1'b0));
        send_item(make_item(CMD_REPLY, 40'd5031, 6'd63, 16'd0, 1'b0, 16'd0, 1'b0));
    endtask

    task automatic test_dead_and_late_clock();
        send_item(make_item(CMD_TICK, 40'd10016, 6'd0, 16'd0, 1'b1, 16'd0, 1'b0));
        send_item(make_item(CMD_REPLY, 40'd400000, 6'd0, 16'd1, 1'b0, 16'd0, 1'b0));
        // clock behind the last response
        send_item(make_item(CMD_TICK, 40'd365016, 6'd0, 16'd0, 1'b1, 16'd0, 1'b0));
        send_item(make_item(CMD_TICK, 40'd790000, 6'd0, 16'd0, 1'b1, 16'd0, 1'b0));
    endtask

    task automatic test_negative_limits_and_wrap();
        load_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(make_item(CMD_ARM, 40'd800000, 6'd63, 16'd0, 1'b0, 16'd0, 1'b1));
        send_item(make_item(CMD_TICK, 40'd800000, 6'd0, 16'd0, 1'b1, 16'd0, 1'b0));
        send_item(make_item(CMD_TICK, 40'd1150000, 6'd0, 16'd0, 1'b1, 16'd0, 1'b0));
        send_item(make_item(CMD_REPLY, 40'd1150000, 6'd0, want_seq[0], 1'b0, 16'd0, 1'b0));
        send_item(make_item(CMD_TICK, 40'd1150000, 6'd0, 16'd0, 1'b0, 16'd0, 1'b0));
        // first check lands past the top of the time range
        send_item(make_item(CMD_ARM, 40'hFF_FFFF_FFF6, 6'd5, 16'd0, 1'b0, 16'hFFFF, 1'b1));
        send_item(make_item(CMD_TICK, 40'hFF_FFFF_FFFF, 6'd0, 16'd0, 1'b1, 16'd0, 1'b0));
    endtask

    task automatic test_random_traffic();
        bit [31:0] iv;
        bit [31:0] qv;
        bit [31:0] dv;
        bit [39:0] clock_ms;
        bit [39:0] soon;
        bit [95:0] noise;
        bit        any;
        int        lo;
        int        span;
        int        r;
        int        h;
        int        counted;
        int        cand[$];
        in_item_t  it;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin iv = 0; qv = 0; dv = 0; end
                3: begin iv = '1; qv = '1; dv = '1; end
                5: begin iv = '1; qv = 0; dv = 0; end
                7: begin iv = $urandom; qv = $urandom; dv = $urandom; end
                9:
                begin
                    iv = $urandom_range(100, 800);
                    qv = $urandom_range(iv + 1, 3000);
                    dv = $urandom_range(iv + 1, 3000);
                end
                default:
                begin
                    iv = $urandom_range(200, 3000);
                    qv = $urandom_range(1, iv / 4);
                    dv = $urandom_range(0, iv / 2);
                end
            endcase
            load_config(iv, qv, dv);
            steady = ($urandom_range(0, 3) == 0);
            clock_ms = {8'($urandom), $urandom};
            lo = $urandom_range(0, HOSTS - 1);
            span = ($urandom_range(0, 4) == 0) ? HOSTS : $urandom_range(2, 12);
            for (int k = 0; k < span && k < 6; k++)
            begin
                clock_ms += $urandom_range(0, 5);
                send_item(make_item(CMD_ARM, clock_ms, 6'(lo + k), 16'($urandom), 1'($urandom),
                                    16'($urandom_range(0, 300)), 1'b1));
            end
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                noise = {$urandom, $urandom, $urandom};
                it = in_item_t'(noise[$bits(in_item_t)-1:0]);
                it.host = ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                                      : 6'(lo + $urandom_range(0, span - 1));
                any = 1'b0;
                soon = '0;
                cand.delete();
                for (int k = 0; k < HOSTS; k++)
                begin
                    if (armed_tbl[k] && (!any || due_ms[k] < soon))
                    begin
                        soon = due_ms[k];
                        any = 1'b1;
                    end
                    // a reply never reads an entry that was never written
                    if (ever_armed[k] && (!armed_tbl[k] || seq_known[k]))
                        cand.push_back(k);
                end
                r = $urandom_range(0, 99);
                if (r < 2)
                    it.cmd = CMD_UNUSED;
                else if (r < 14 || !any)
                begin
                    it.cmd = CMD_ARM;
                    it.enable = ($urandom_range(0, 4) != 0);
                    it.jitter_ms = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 300));
                    clock_ms += $urandom_range(0, 5);
                    it.now_ms = clock_ms;
                    counted++;
                end
                else if (r < 40 && cand.size() > 0)
                begin
                    h = cand[$urandom_range(0, cand.size() - 1)];
                    it.cmd = CMD_REPLY;
                    it.host = 6'(h);
                    if (armed_tbl[h] && $urandom_range(0, 3) != 0)
                        it.reply_seq = want_seq[h];
                    clock_ms += $urandom_range(0, 30);
                    it.now_ms = clock_ms;
                    counted++;
                end
                else
                begin
                    it.cmd = CMD_TICK;
                    it.link_ok = ($urandom_range(0, 7) != 0);
                    r = $urandom_range(0, 9);
                    if (r < 7)
                    begin
                        if (soon > clock_ms)
                            clock_ms = soon;
                        clock_ms += $urandom_range(0, 3);
                        it.now_ms = clock_ms;
                    end
                    else if (r < 9)
                    begin
                        clock_ms += $urandom_range(0, 400);
                        it.now_ms = clock_ms;
                    end
                    else
                        it.now_ms = clock_ms - $urandom_range(1, 2000);
                    counted++;
                end
                send_item(it);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_events.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, out_data);
                fail_count++;
            end
            else
            begin
                head_event = owed_events.pop_front();
                field_check("host_index", head_event.host_index, out_data.host_index);
                field_check("event_kind", head_event.event_kind, out_data.event_kind);
                field_check("ping_request", head_event.ping_request, out_data.ping_request);
                field_check("ping_number", head_event.ping_number, out_data.ping_number);
                field_check("host_live", head_event.host_live, out_data.host_live);
                field_check("went_dead", head_event.went_dead, out_data.went_dead);
                field_check("went_live", head_event.went_live, out_data.went_live);
                field_check("next_due_ms", head_event.next_due_ms, out_data.next_due_ms);
                results_seen++;
                pings_seen += head_event.ping_request;
                deaths_seen += head_event.went_dead;
                lives_seen += head_event.went_live;
            end
        end
        if (stall_left == 0)
        begin
            stall_on = !steady && ($urandom_range(0, 2) == 0);
            if (!stall_on)
                stall_left = $urandom_range(1, 12);
            else if ($urandom_range(0, 7) == 0)
                stall_left = $urandom_range(10, 40);
            else
                stall_left = $urandom_range(1, 3);
        end
        stall_left--;
        out_stall <= stall_on;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, owed_events.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int drain;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_startup_ping();
        test_replies();
        test_dead_and_late_clock();
        test_negative_limits_and_wrap();
        test_random_traffic();
        in_valid <= 1'b0;
        drain = 0;
        while (owed_events.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (owed_events.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, owed_events.size());
            fail_count += owed_events.size();
        end
        repeat (HOSTS + 20) @(posedge clk);
        $display("Sent %0d items: directed corner cases, then %0d register settings of random traffic",
                 items_sent, PHASES);
        $display("Checked %0d results: %0d pings, %0d hosts went live, %0d went dead",
                 results_seen, pings_seen, lives_seen, deaths_seen);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
